// ===== rtl/sha1md_pkg.sv =====
// Package for the SHA-1 digest core: initial chain words, round constants,
// block layout constants, round function and the controller/datapath structs.
// No dependencies.
`default_nettype none

package sha1md_pkg;

  localparam int unsigned NUM_ROUNDS = 80;

  // Byte slots in a 512-bit block
  localparam logic [5:0] POS_LAST = 6'd63;  // last slot of a block
  localparam logic [5:0] POS_FIT  = 6'd54;  // last slot that leaves room for 0x80 and length
  localparam logic [5:0] POS_NOFIT = 6'd55; // from here on the length needs another block

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [63:0] LEN_STEP = 64'd8;
  localparam logic [31:0] PAD_LEAD_WORD = 32'h8000_0000;

  localparam logic [6:0] ROUND_LAST = 7'(NUM_ROUNDS - 1);
  localparam logic [6:0] GRP1_START = 7'd20;
  localparam logic [6:0] GRP2_START = 7'd40;
  localparam logic [6:0] GRP3_START = 7'd60;

  localparam logic [31:0] CHAIN_INIT [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  typedef enum logic [1:0] {
    GRP_CHOOSE = 2'd0,
    GRP_PARITY1 = 2'd1,
    GRP_MAJORITY = 2'd2,
    GRP_PARITY2 = 2'd3
  } grp_t;

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic byte_we;     // accept transaction: write byte, pad if last
    logic load_blk;    // start a compression on the buffered block
    logic load_extra;  // start a compression on a length-only pad block
    logic extra_lead;  // pad block opens with the 0x80 byte
    logic round_en;    // run one round
    grp_t grp;         // round group of the current round
    logic feed_fwd;    // add working words into the chain
    logic finish;      // capture digest, restore chain and length
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;   // next free byte slot
  } sts_t;

  function automatic logic [31:0] round_fn(grp_t g, logic [31:0] b, logic [31:0] c,
                                           logic [31:0] d);
    logic [31:0] f;
    case (g)
      GRP_CHOOSE:   f = (b & c) | (~b & d);
      GRP_MAJORITY: f = (b & c) | (b & d) | (c & d);
      default:      f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1md_if.sv =====
// Valid/ready channel interfaces of the SHA-1 digest core: byte input and
// digest output. No dependencies.
`default_nettype none

interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       is_last;

  modport source (output valid, message_byte, is_last, input ready);
  modport sink   (input valid, message_byte, is_last, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, input ready);
  modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, output ready);
endinterface

`default_nettype wire

// ===== rtl/sha1_message_digest_core.sv =====
// SHA-1 digest core, one message byte per transaction, digest as five words.
// Bytes enter at one per cycle while the block buffer has room; a full block
// then runs 80 rounds on the single round unit. When the length does not fit,
// an extra padding block follows. No new message is taken until the digest
// sits in the output register. Synchronous active-low reset loads the initial
// chain value and empties the buffer.
`default_nettype none

module sha1_message_digest_core import sha1md_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sha1md_in_if.sink     in_chan,
  sha1md_out_if.source  out_chan
);

  cmd_t             cmd;
  sts_t             sts;
  logic [4:0][31:0] digest;
  logic             in_ready;
  logic             out_valid;

  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_is_last (in_chan.is_last),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_chan.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha1md_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_chan.message_byte),
    .in_is_last (in_chan.is_last),
    .sts        (sts),
    .digest     (digest)
  );

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid;
  assign out_chan.digest_word0 = digest[0];
  assign out_chan.digest_word1 = digest[1];
  assign out_chan.digest_word2 = digest[2];
  assign out_chan.digest_word3 = digest[3];
  assign out_chan.digest_word4 = digest[4];

endmodule

`default_nettype wire

// ===== rtl/sha1md_dp.sv =====
// Datapath of the SHA-1 digest core: block buffer with padding, message
// schedule window, round unit, chain value, length counter, digest register.
// Depends on sha1md_pkg.
`default_nettype none

module sha1md_dp import sha1md_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [7:0]       in_byte,
  input  logic             in_is_last,
  output sts_t             sts,
  output logic [4:0][31:0] digest
);

  logic [31:0] chain_r [5];
  logic [31:0] chain_nxt [5];
  logic [63:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;

  logic [31:0] blk_r [16];
  logic [31:0] blk_nxt [16];
  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];
  logic [31:0] wv_r [5];
  logic [31:0] wv_nxt [5];
  logic [4:0][31:0] digest_r, digest_nxt;

  logic [63:0] len_new;
  logic [6:0]  pos_p1;
  logic        fits;
  logic [31:0] sched_new;
  logic [31:0] round_sum;

  assign len_new = len_r + LEN_STEP;
  assign pos_p1  = {1'b0, pos_r} + 7'd1;
  assign fits    = (pos_r <= POS_FIT);

  assign sched_new = {win_r[13][30:0] ^ win_r[8][30:0] ^ win_r[2][30:0] ^ win_r[0][30:0],
                      win_r[13][31] ^ win_r[8][31] ^ win_r[2][31] ^ win_r[0][31]};

  assign round_sum = {wv_r[0][26:0], wv_r[0][31:27]}
                   + round_fn(cmd.grp, wv_r[1], wv_r[2], wv_r[3])
                   + wv_r[4] + win_r[0] + ROUND_K[cmd.grp];

  // Byte write and padding into the block buffer
  always_comb begin
    logic [6:0] k;
    k = '0;
    for (int w = 0; w < 16; w++) begin
      blk_nxt[w] = blk_r[w];
    end
    pos_nxt = pos_r;
    len_nxt = len_r;
    if (cmd.byte_we) begin
      for (int w = 0; w < 16; w++) begin
        for (int b = 0; b < 4; b++) begin
          k = 7'(4 * w + b);
          if (k == {1'b0, pos_r}) begin
            blk_nxt[w][31 - 8 * b -: 8] = in_byte;
          end else if (in_is_last && k == pos_p1) begin
            blk_nxt[w][31 - 8 * b -: 8] = PAD_BYTE;
          end else if (in_is_last && k > pos_p1) begin
            blk_nxt[w][31 - 8 * b -: 8] = 8'h00;
          end
        end
      end
      if (in_is_last && fits) begin
        blk_nxt[14] = len_new[63:32];
        blk_nxt[15] = len_new[31:0];
      end
      len_nxt = len_new;
      pos_nxt = (in_is_last || pos_r == POS_LAST) ? 6'd0 : pos_r + 6'd1;
    end
    if (cmd.finish) begin
      len_nxt = '0;
    end
  end

  // Schedule window, working words, chain and digest
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_nxt[i] = win_r[i];
    end
    for (int i = 0; i < 5; i++) begin
      wv_nxt[i]    = wv_r[i];
      chain_nxt[i] = chain_r[i];
    end
    digest_nxt = digest_r;

    if (cmd.load_blk) begin
      for (int i = 0; i < 16; i++) begin
        win_nxt[i] = blk_r[i];
      end
      for (int i = 0; i < 5; i++) begin
        wv_nxt[i] = chain_r[i];
      end
    end else if (cmd.load_extra) begin
      for (int i = 0; i < 16; i++) begin
        win_nxt[i] = '0;
      end
      win_nxt[0]  = cmd.extra_lead ? PAD_LEAD_WORD : 32'h0;
      win_nxt[14] = len_r[63:32];
      win_nxt[15] = len_r[31:0];
      for (int i = 0; i < 5; i++) begin
        wv_nxt[i] = chain_r[i];
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[15] = sched_new;
      wv_nxt[0] = round_sum;
      wv_nxt[1] = wv_r[0];
      wv_nxt[2] = {wv_r[1][1:0], wv_r[1][31:2]};
      wv_nxt[3] = wv_r[2];
      wv_nxt[4] = wv_r[3];
    end

    if (cmd.feed_fwd) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = chain_r[i] + wv_r[i];
      end
    end else if (cmd.finish) begin
      for (int i = 0; i < 5; i++) begin
        digest_nxt[i] = chain_r[i];
        chain_nxt[i]  = CHAIN_INIT[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= CHAIN_INIT[i];
      end
      len_r <= '0;
      pos_r <= '0;
    end else begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
      len_r <= len_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      blk_r[i] <= blk_nxt[i];
      win_r[i] <= win_nxt[i];
    end
    for (int i = 0; i < 5; i++) begin
      wv_r[i] <= wv_nxt[i];
    end
    digest_r <= digest_nxt;
  end

  assign sts.pos = pos_r;
  assign digest  = digest_r;

endmodule

`default_nettype wire

// ===== rtl/sha1md_ctrl.sv =====
// Controller of the SHA-1 digest core: block bookkeeping, round sequencing,
// padding decisions and the output valid flag.
// Depends on sha1md_pkg.
`default_nettype none

module sha1md_ctrl import sha1md_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_is_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_FILL  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_EXTRA = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] round_r, round_nxt;
  logic       blk_full_r, blk_full_nxt;
  logic       closing_r, closing_nxt;
  logic       pend_final_r, pend_final_nxt;
  logic       pend_extra_r, pend_extra_nxt;
  logic       pend_lead_r, pend_lead_nxt;
  logic       cur_final_r, cur_final_nxt;
  logic       cur_extra_r, cur_extra_nxt;
  logic       cur_lead_r, cur_lead_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // Hold off bytes while a complete block waits or a message is closing
  assign in_ready = !blk_full_r && !closing_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    round_nxt      = round_r;
    blk_full_nxt   = blk_full_r;
    closing_nxt    = closing_r;
    pend_final_nxt = pend_final_r;
    pend_extra_nxt = pend_extra_r;
    pend_lead_nxt  = pend_lead_r;
    cur_final_nxt  = cur_final_r;
    cur_extra_nxt  = cur_extra_r;
    cur_lead_nxt   = cur_lead_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    cmd            = '0;
    cmd.byte_we    = accept;
    cmd.extra_lead = cur_lead_r;
    if (round_r < GRP1_START) begin
      cmd.grp = GRP_CHOOSE;
    end else if (round_r < GRP2_START) begin
      cmd.grp = GRP_PARITY1;
    end else if (round_r < GRP3_START) begin
      cmd.grp = GRP_MAJORITY;
    end else begin
      cmd.grp = GRP_PARITY2;
    end

    if (accept && (in_is_last || sts.pos == POS_LAST)) begin
      blk_full_nxt   = 1'b1;
      pend_final_nxt = in_is_last;
      pend_extra_nxt = in_is_last && (sts.pos >= POS_NOFIT);
      pend_lead_nxt  = in_is_last && (sts.pos == POS_LAST);
    end
    if (accept && in_is_last) begin
      closing_nxt = 1'b1;
    end

    case (state_r)
      ST_FILL: begin
        if (blk_full_r) begin
          cmd.load_blk  = 1'b1;
          blk_full_nxt  = 1'b0;
          cur_final_nxt = pend_final_r;
          cur_extra_nxt = pend_extra_r;
          cur_lead_nxt  = pend_lead_r;
          round_nxt     = '0;
          state_nxt     = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 7'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.feed_fwd = 1'b1;
        if (!cur_final_r) begin
          state_nxt = ST_FILL;
        end else if (cur_extra_r) begin
          state_nxt = ST_EXTRA;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_EXTRA: begin
        cmd.load_extra = 1'b1;
        cur_extra_nxt  = 1'b0;
        round_nxt      = '0;
        state_nxt      = ST_RUN;
      end
      ST_OUT: begin
        // Wait for the digest register to drain
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          closing_nxt   = 1'b0;
          state_nxt     = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      round_r      <= '0;
      blk_full_r   <= 1'b0;
      closing_r    <= 1'b0;
      pend_final_r <= 1'b0;
      pend_extra_r <= 1'b0;
      pend_lead_r  <= 1'b0;
      cur_final_r  <= 1'b0;
      cur_extra_r  <= 1'b0;
      cur_lead_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      round_r      <= round_nxt;
      blk_full_r   <= blk_full_nxt;
      closing_r    <= closing_nxt;
      pend_final_r <= pend_final_nxt;
      pend_extra_r <= pend_extra_nxt;
      pend_lead_r  <= pend_lead_nxt;
      cur_final_r  <= cur_final_nxt;
      cur_extra_r  <= cur_extra_nxt;
      cur_lead_r   <= cur_lead_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
